// ===== rtl/owm_pkg.sv =====
// Package: shared types and constants for the one-wire bus master.
`timescale 1ns / 1ps

package owm_pkg;

    localparam int TIMER_W = 14;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [2:0] CFG_PRES_WAIT     = 3'd1;
    localparam logic [2:0] CFG_PRES_RETRY    = 3'd2;
    localparam logic [2:0] CFG_PRES_TRIES    = 3'd3;
    localparam logic [2:0] CFG_RESET_RECOVER = 3'd4;
    localparam logic [2:0] CFG_SLOT_LOW      = 3'd5;
    localparam logic [2:0] CFG_SLOT_HOLD     = 3'd6;
    localparam logic [2:0] CFG_READ_SAMPLE   = 3'd7;

    localparam logic [TIMER_W-1:0] PRE_RESET_US = TIMER_W'(50);
    localparam logic [TIMER_W-1:0] WRITE_GAP_US = TIMER_W'(2);
    localparam logic [3:0]         BITS_PER_BYTE = 4'd8;

    typedef enum logic [12:0] {
        PH_IDLE    = 13'b0000000000001,
        PH_R_PRE   = 13'b0000000000010,
        PH_R_LOW   = 13'b0000000000100,
        PH_R_WAIT  = 13'b0000000001000,
        PH_R_RETRY = 13'b0000000010000,
        PH_R_RECOV = 13'b0000000100000,
        PH_W_LOW   = 13'b0000001000000,
        PH_W_HOLD  = 13'b0000010000000,
        PH_W_GAP   = 13'b0000100000000,
        PH_RD_PRE  = 13'b0001000000000,
        PH_RD_LOW  = 13'b0010000000000,
        PH_RD_REL  = 13'b0100000000000,
        PH_RD_HOLD = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        logic [9:0]  reset_low_us;
        logic [7:0]  presence_wait_us;
        logic [13:0] presence_retry_us;
        logic [3:0]  presence_tries;
        logic [9:0]  reset_recover_us;
        logic [5:0]  slot_low_us;
        logic [7:0]  slot_hold_us;
        logic [5:0]  read_sample_us;
    } t_cfg;

    typedef struct packed {
        logic       cmd_rejected;
        logic [7:0] read_data;
        logic       presence_ok;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } t_res;

endpackage

// ===== rtl/owm_core.sv =====
// Bus master state machine: timer, bit and try counters, one step per transaction.
`timescale 1ns / 1ps

module owm_core
    import owm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_write_data,
    input  logic       i_line_level,
    input  t_cfg       i_cfg,
    output t_res       o_res
);

    t_phase             r_phase, n_phase;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [3:0]         r_bit_cnt, n_bit_cnt;
    logic [7:0]         r_shift, n_shift;
    logic [3:0]         r_try_cnt, n_try_cnt;
    logic               r_presence, n_presence;
    logic               r_drive, n_drive;
    logic [7:0]         r_read, n_read;
    logic               done, rej;
    logic [3:0]         bit_inc;
    logic [3:0]         try_inc;

    assign bit_inc = r_bit_cnt + 4'd1;
    assign try_inc = r_try_cnt + 4'd1;

    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_try_cnt  = r_try_cnt;
        n_presence = r_presence;
        n_drive    = r_drive;
        n_read     = r_read;
        done       = 1'b0;
        rej        = 1'b0;

        if (i_req_type == REQ_TICK) begin
            if (r_phase != PH_IDLE) begin
                if (r_timer > TIMER_W'(1)) begin
                    n_timer = r_timer - TIMER_W'(1);
                end else begin
                    n_timer = '0;
                    case (r_phase)
                        PH_R_PRE: begin
                            n_phase = PH_R_LOW;
                            n_timer = TIMER_W'(i_cfg.reset_low_us);
                            n_drive = 1'b1;
                        end
                        PH_R_LOW: begin
                            n_phase = PH_R_WAIT;
                            n_timer = TIMER_W'(i_cfg.presence_wait_us);
                            n_drive = 1'b0;
                        end
                        PH_R_WAIT, PH_R_RETRY: begin
                            n_drive = 1'b0;
                            if (r_phase == PH_R_RETRY && r_try_cnt >= i_cfg.presence_tries) begin
                                n_presence = 1'b0;
                                n_phase    = PH_IDLE;
                                n_timer    = '0;
                                done       = 1'b1;
                            end else if (!i_line_level) begin
                                n_phase = PH_R_RECOV;
                                n_timer = TIMER_W'(i_cfg.reset_recover_us);
                            end else begin
                                n_try_cnt = try_inc;
                                n_phase   = PH_R_RETRY;
                                n_timer   = i_cfg.presence_retry_us;
                            end
                        end
                        PH_R_RECOV: begin
                            n_presence = 1'b1;
                            n_phase    = PH_IDLE;
                            n_drive    = 1'b0;
                            done       = 1'b1;
                        end
                        PH_W_LOW: begin
                            n_phase = PH_W_HOLD;
                            n_timer = TIMER_W'(i_cfg.slot_hold_us);
                            n_drive = ~r_shift[0];
                        end
                        PH_W_HOLD: begin
                            n_phase = PH_W_GAP;
                            n_timer = WRITE_GAP_US;
                            n_drive = 1'b0;
                        end
                        PH_W_GAP: begin
                            n_shift   = {1'b0, r_shift[7:1]};
                            n_bit_cnt = bit_inc;
                            if (bit_inc >= BITS_PER_BYTE) begin
                                n_phase = PH_IDLE;
                                n_drive = 1'b0;
                                done    = 1'b1;
                            end else begin
                                n_phase = PH_W_LOW;
                                n_timer = TIMER_W'(i_cfg.slot_low_us);
                                n_drive = 1'b1;
                            end
                        end
                        PH_RD_PRE: begin
                            n_phase = PH_RD_LOW;
                            n_timer = TIMER_W'(i_cfg.slot_low_us);
                            n_drive = 1'b1;
                        end
                        PH_RD_LOW: begin
                            n_phase = PH_RD_REL;
                            n_timer = TIMER_W'(i_cfg.read_sample_us);
                            n_drive = 1'b0;
                        end
                        PH_RD_REL: begin
                            n_shift = {i_line_level, r_shift[7:1]};
                            n_phase = PH_RD_HOLD;
                            n_timer = TIMER_W'(i_cfg.slot_hold_us);
                            n_drive = 1'b0;
                        end
                        PH_RD_HOLD: begin
                            n_bit_cnt = bit_inc;
                            if (bit_inc >= BITS_PER_BYTE) begin
                                n_read  = r_shift;
                                n_phase = PH_IDLE;
                                n_drive = 1'b0;
                                done    = 1'b1;
                            end else begin
                                n_phase = PH_RD_LOW;
                                n_timer = TIMER_W'(i_cfg.slot_low_us);
                                n_drive = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_drive = 1'b0;
                        end
                    endcase
                end
            end
        end else if (r_phase != PH_IDLE) begin
            rej = 1'b1;
        end else if (i_req_type == REQ_RESET) begin
            n_try_cnt = '0;
            n_phase   = PH_R_PRE;
            n_timer   = PRE_RESET_US;
            n_drive   = 1'b0;
        end else if (i_req_type == REQ_WRITE) begin
            n_shift   = i_write_data;
            n_bit_cnt = '0;
            n_phase   = PH_W_LOW;
            n_timer   = TIMER_W'(i_cfg.slot_low_us);
            n_drive   = 1'b1;
        end else begin
            n_shift   = '0;
            n_bit_cnt = '0;
            n_phase   = PH_RD_PRE;
            n_timer   = TIMER_W'(i_cfg.read_sample_us);
            n_drive   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_bit_cnt  <= '0;
            r_shift    <= '0;
            r_try_cnt  <= '0;
            r_presence <= 1'b0;
            r_drive    <= 1'b0;
            r_read     <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
            r_try_cnt  <= n_try_cnt;
            r_presence <= n_presence;
            r_drive    <= n_drive;
            r_read     <= n_read;
        end
    end

    always_comb begin
        o_res.drive_low    = n_drive;
        o_res.busy_res     = (n_phase != PH_IDLE);
        o_res.done_res     = done;
        o_res.presence_ok  = n_presence;
        o_res.read_data    = n_read;
        o_res.cmd_rejected = rej;
    end

endmodule

// ===== rtl/one_wire_bus_master.sv =====
// Top level: one-wire bus master with stream channels and configuration registers.
//
// Usage: each transaction on the s_axis channel is either a one-microsecond tick
// or a command (bus reset with presence detect, write byte, read byte). Every
// accepted transaction yields exactly one result transaction on m_axis carrying
// the line drive, busy, done, presence and read byte, plus a reject flag for a
// command that arrived while busy.
// The result of a transaction sits in the output register on the cycle after
// it is accepted.
// Throughput: one transaction per cycle while m_axis takes each result. The state step
// is a single pass of logic from the input to the state and output registers.
// Stall: while the output register holds a result that m_axis has not taken,
// s_axis tready is low; it goes high in the same cycle m_axis tready frees
// the register, so the stream runs at full rate with a ready sink.
// Reset (i_rst_n, synchronous, active low): the master goes idle with the line
// released, presence failed, read byte zero, and all timing registers back
// to their defaults; the output register is empty.
// Configuration writes are taken whenever i_cfg_we is high; they must only
// be issued while no operation is in progress.
`timescale 1ns / 1ps

module one_wire_bus_master
    import owm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [13:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // req_type[1:0], write_data[9:2], line_level[10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // drive_low[0], busy_res[1], done_res[2],
                                       // presence_ok[3], read_data[11:4], cmd_rejected[12]
);

    t_cfg  r_cfg;
    t_res  res;
    t_res  r_res;
    logic  r_out_valid;
    logic  accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_us      <= 10'd500;
            r_cfg.presence_wait_us  <= 8'd40;
            r_cfg.presence_retry_us <= 14'd10000;
            r_cfg.presence_tries    <= 4'd10;
            r_cfg.reset_recover_us  <= 10'd500;
            r_cfg.slot_low_us       <= 6'd5;
            r_cfg.slot_hold_us      <= 8'd65;
            r_cfg.read_sample_us    <= 6'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESET_LOW:     r_cfg.reset_low_us      <= i_cfg_wdata[9:0];
                CFG_PRES_WAIT:     r_cfg.presence_wait_us  <= i_cfg_wdata[7:0];
                CFG_PRES_RETRY:    r_cfg.presence_retry_us <= i_cfg_wdata;
                CFG_PRES_TRIES:    r_cfg.presence_tries    <= i_cfg_wdata[3:0];
                CFG_RESET_RECOVER: r_cfg.reset_recover_us  <= i_cfg_wdata[9:0];
                CFG_SLOT_LOW:      r_cfg.slot_low_us       <= i_cfg_wdata[5:0];
                CFG_SLOT_HOLD:     r_cfg.slot_hold_us      <= i_cfg_wdata[7:0];
                CFG_READ_SAMPLE:   r_cfg.read_sample_us    <= i_cfg_wdata[5:0];
                default:           r_cfg.read_sample_us    <= r_cfg.read_sample_us;
            endcase
        end
    end

    owm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (s_axis_tdata[1:0]),
        .i_write_data (s_axis_tdata[9:2]),
        .i_line_level (s_axis_tdata[10]),
        .i_cfg        (r_cfg),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_res};

endmodule

// ===== sim/tb.sv =====
// Testbench for one_wire_bus_master: checks every status transaction against a model.
`timescale 1ns / 1ps

module tb;
    import owm_pkg::*;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] data;
        logic       level;
    } t_bus_req;

    localparam int STUCK_LIMIT = 5000;
    localparam int REG_W [8] = '{10, 8, 14, 4, 10, 6, 8, 6};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [13:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // req_type[1:0], write_data[9:2], line_level[10]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // drive_low[0], busy_res[1], done_res[2],
                                      // presence_ok[3], read_data[11:4], cmd_rejected[12]

    one_wire_bus_master uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // model state
    t_phase      ph_m = PH_IDLE;
    logic [13:0] tmr_m = '0;
    logic [3:0]  bitcnt_m = '0;
    logic [3:0]  tries_m = '0;
    logic [7:0]  sh_m = '0;
    logic [7:0]  rdbyte_m = '0;
    logic        pres_m = 1'b0;
    logic        drv_m = 1'b0;
    logic [13:0] regs_m [8] = '{14'd500, 14'd40, 14'd10000, 14'd10, 14'd500, 14'd5, 14'd65,
                                14'd5};

    t_bus_req bus_req_q [$];
    t_res     owm_status_q [$];

    int  mismatches = 0;
    int  n_status = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stuck_cnt = 0;
    int  hold_left = 0;
    int  pat_left = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    logic [7:0] ready_pat = 8'hFF;
    int  plan [8];
    t_bus_req nxt;
    t_res got, want;

    function automatic void enter(t_phase p, logic [13:0] t, logic d);
        ph_m = p;
        tmr_m = t;
        drv_m = d;
    endfunction

    function automatic void sample_presence(logic lvl);
        if (!lvl) begin
            enter(PH_R_RECOV, regs_m[CFG_RESET_RECOVER], 1'b0);
        end else begin
            tries_m = tries_m + 4'd1;
            enter(PH_R_RETRY, regs_m[CFG_PRES_RETRY], 1'b0);
        end
    endfunction

    // end of the current wait; returns 1 when the operation completes
    function automatic logic timer_expired(logic lvl);
        logic fin;
        fin = 1'b0;
        case (ph_m)
            PH_R_PRE:   enter(PH_R_LOW, regs_m[CFG_RESET_LOW], 1'b1);
            PH_R_LOW:   enter(PH_R_WAIT, regs_m[CFG_PRES_WAIT], 1'b0);
            PH_R_WAIT:  sample_presence(lvl);
            PH_R_RETRY: begin
                if (tries_m >= regs_m[CFG_PRES_TRIES]) begin
                    pres_m = 1'b0;
                    enter(PH_IDLE, '0, 1'b0);
                    fin = 1'b1;
                end else begin
                    sample_presence(lvl);
                end
            end
            PH_R_RECOV: begin
                pres_m = 1'b1;
                enter(PH_IDLE, '0, 1'b0);
                fin = 1'b1;
            end
            PH_W_LOW:   enter(PH_W_HOLD, regs_m[CFG_SLOT_HOLD], ~sh_m[0]);
            PH_W_HOLD:  enter(PH_W_GAP, WRITE_GAP_US, 1'b0);
            PH_W_GAP: begin
                sh_m = sh_m >> 1;
                bitcnt_m = bitcnt_m + 4'd1;
                if (bitcnt_m >= BITS_PER_BYTE) begin
                    enter(PH_IDLE, '0, 1'b0);
                    fin = 1'b1;
                end else begin
                    enter(PH_W_LOW, regs_m[CFG_SLOT_LOW], 1'b1);
                end
            end
            PH_RD_PRE:  enter(PH_RD_LOW, regs_m[CFG_SLOT_LOW], 1'b1);
            PH_RD_LOW:  enter(PH_RD_REL, regs_m[CFG_READ_SAMPLE], 1'b0);
            PH_RD_REL: begin
                sh_m = {lvl, sh_m[7:1]};
                enter(PH_RD_HOLD, regs_m[CFG_SLOT_HOLD], 1'b0);
            end
            PH_RD_HOLD: begin
                bitcnt_m = bitcnt_m + 4'd1;
                if (bitcnt_m >= BITS_PER_BYTE) begin
                    rdbyte_m = sh_m;
                    enter(PH_IDLE, '0, 1'b0);
                    fin = 1'b1;
                end else begin
                    enter(PH_RD_LOW, regs_m[CFG_SLOT_LOW], 1'b1);
                end
            end
            default:    enter(PH_IDLE, '0, 1'b0);
        endcase
        return fin;
    endfunction

    function automatic t_res step_one_wire(logic [1:0] req, logic [7:0] data, logic lvl);
        t_res r;
        logic fin;
        logic rej;
        fin = 1'b0;
        rej = 1'b0;
        if (req == REQ_TICK) begin
            if (ph_m != PH_IDLE) begin
                if (tmr_m <= 14'd1) begin
                    tmr_m = '0;
                    fin = timer_expired(lvl);
                end else begin
                    tmr_m = tmr_m - 14'd1;
                end
            end
        end else if (ph_m != PH_IDLE) begin
            rej = 1'b1;
        end else if (req == REQ_RESET) begin
            tries_m = '0;
            enter(PH_R_PRE, PRE_RESET_US, 1'b0);
        end else if (req == REQ_WRITE) begin
            sh_m = data;
            bitcnt_m = '0;
            enter(PH_W_LOW, regs_m[CFG_SLOT_LOW], 1'b1);
        end else begin
            sh_m = '0;
            bitcnt_m = '0;
            enter(PH_RD_PRE, regs_m[CFG_READ_SAMPLE], 1'b0);
        end
        r.drive_low    = drv_m;
        r.busy_res     = (ph_m != PH_IDLE);
        r.done_res     = fin;
        r.presence_ok  = pres_m;
        r.read_data    = rdbyte_m;
        r.cmd_rejected = rej;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("status %0d: %s expected %0h got %0h at %0t", n_status, what, exp_v, got_v,
                 $realtime);
        mismatches++;
    endtask

    // sender: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                owm_status_q.push_back(step_one_wire(s_axis_tdata[1:0], s_axis_tdata[9:2],
                                                     s_axis_tdata[10]));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (bus_req_q.size() > 0) begin
                    nxt = bus_req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {5'b0, nxt.level, nxt.data, nxt.req};
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 30);
                        gap_left = $urandom_range(0, 10);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotating ready pattern, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
            m_axis_tready <= 1'b0;
        end else begin
            if (pat_left == 0) begin
                ready_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
                pat_left = $urandom_range(16, 200);
            end
            pat_left--;
            m_axis_tready <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[7:1]};
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_res'(m_axis_tdata[12:0]);
            if (owm_status_q.size() == 0) begin
                report_mismatch("status with none pending", 0, m_axis_tdata);
            end else begin
                want = owm_status_q.pop_front();
                if (got.drive_low !== want.drive_low)
                    report_mismatch("drive_low", want.drive_low, got.drive_low);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", want.busy_res, got.busy_res);
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", want.done_res, got.done_res);
                if (got.presence_ok !== want.presence_ok)
                    report_mismatch("presence_ok", want.presence_ok, got.presence_ok);
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, got.read_data);
                if (got.cmd_rejected !== want.cmd_rejected)
                    report_mismatch("cmd_rejected", want.cmd_rejected, got.cmd_rejected);
            end
            n_status++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cnt <= 0;
        end else if (stuck_cnt == STUCK_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stuck_cnt <= stuck_cnt + 1;
        end
    end

    task automatic push_item(input logic [1:0] req, input logic [7:0] data, input logic lvl);
        t_bus_req it;
        it.req = req;
        it.data = data;
        it.level = lvl;
        bus_req_q.push_back(it);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (bus_req_q.size() != 0 || s_axis_tvalid || owm_status_q.size() != 0);
    endtask

    // let any operation in flight run out on ticks with the line held low
    task automatic settle();
        wait_drained();
        while (ph_m != PH_IDLE) begin
            repeat (32) push_item(REQ_TICK, 8'($urandom), 1'b0);
            wait_drained();
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= 14'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        regs_m[idx] = 14'(v & ((1 << REG_W[idx]) - 1));
    endtask

    task automatic load_plan();
        settle();
        repeat (2) @(posedge i_clk);
        for (int i = 0; i < 8; i++) write_reg(3'(i), plan[i]);
        @(negedge i_clk);
    endtask

    // mostly a command followed by a run of ticks; some raw noise
    task automatic random_traffic(input int n);
        int cnt;
        int len;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(0, 9) < 8) begin
                push_item(2'($urandom_range(REQ_RESET, REQ_READ)), 8'($urandom), 1'($urandom));
                cnt++;
                len = $urandom_range(10, 90);
                repeat (len) begin
                    if ($urandom_range(0, 19) == 0)
                        push_item(2'($urandom_range(REQ_RESET, REQ_READ)), 8'($urandom),
                                  1'($urandom));
                    else
                        push_item(REQ_TICK, 8'($urandom), 1'($urandom));
                    cnt++;
                end
            end else begin
                len = $urandom_range(1, 8);
                repeat (len) begin
                    push_item(2'($urandom_range(REQ_TICK, REQ_READ)), 8'($urandom), 1'($urandom));
                    cnt++;
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // power-up timing: idle ticks, then a write at the default slot timing
        push_item(REQ_TICK, 8'h00, 1'b0);
        push_item(REQ_TICK, 8'hFF, 1'b1);
        push_item(REQ_WRITE, 8'hA5, 1'b1);
        settle();

        // all timing registers zero: zero times act as one, zero tries
        for (int i = 0; i < 8; i++) plan[i] = 0;
        load_plan();
        push_item(REQ_TICK, 8'h5A, 1'b1);
        push_item(REQ_RESET, 8'hFF, 1'b1);
        push_item(REQ_WRITE, 8'hFF, 1'b0);
        push_item(REQ_READ, 8'h00, 1'b1);
        push_item(REQ_RESET, 8'h00, 1'b0);
        repeat (60) push_item(REQ_TICK, 8'($urandom), 1'b1);
        push_item(REQ_WRITE, 8'h00, 1'b0);
        repeat (34) push_item(REQ_TICK, 8'($urandom), 1'($urandom));
        push_item(REQ_WRITE, 8'hFF, 1'b1);
        repeat (34) push_item(REQ_TICK, 8'($urandom), 1'($urandom));
        push_item(REQ_READ, 8'hFF, 1'b0);
        repeat (30) push_item(REQ_TICK, 8'($urandom), 1'($urandom));
        push_item(REQ_RESET, 8'h00, 1'b1);
        repeat (60) push_item(REQ_TICK, 8'($urandom), 1'b0);
        settle();

        // registers but presence_retry written with ones above their width; only the low bits count
        plan[CFG_RESET_LOW]     = 'h3C03;
        plan[CFG_PRES_WAIT]     = 'h3F02;
        plan[CFG_PRES_RETRY]    = 20;
        plan[CFG_PRES_TRIES]    = 'h3FF2;
        plan[CFG_RESET_RECOVER] = 'h3C04;
        plan[CFG_SLOT_LOW]      = 'h3FC3;
        plan[CFG_SLOT_HOLD]     = 'h3F05;
        plan[CFG_READ_SAMPLE]   = 'h3FC2;
        load_plan();
        push_item(REQ_WRITE, 8'h5A, 1'b0);
        settle();
        push_item(REQ_READ, 8'h00, 1'b0);
        repeat (90) push_item(REQ_TICK, 8'($urandom), 1'($urandom));
        settle();
        push_item(REQ_RESET, 8'h00, 1'b1);
        repeat (120) push_item(REQ_TICK, 8'($urandom), 1'b1);
        settle();
        push_item(REQ_RESET, 8'h00, 1'b0);
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < 8; i++) plan[i] = $urandom_range(0, 4);
            plan[CFG_PRES_TRIES] = $urandom_range(0, 3);
            if (ph == 5) plan[CFG_PRES_RETRY] = $urandom_range(0, 30);
            load_plan();
            if (ph == 1) hold_req = 1'b1;
            random_traffic(90);
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
